### hw/rtl/nnd_pkg.sv
package nnd_pkg;

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_MAX_DIM    = 2'd2
  } reg_idx_t;

  // Widths fixed by the field definitions.
  localparam int CFG_W   = 13;
  localparam int IDX_W   = 2;
  localparam int COLOR_W = 8;
  localparam int POS_W   = 12;
  localparam int IN_W    = 3 * COLOR_W;
  localparam int OUT_W   = 3 * COLOR_W + 2 * POS_W;

  // Reset values of the configuration registers.
  localparam logic [CFG_W-1:0] RST_SRC_WIDTH  = 13'd640;
  localparam logic [CFG_W-1:0] RST_SRC_HEIGHT = 13'd480;
  localparam logic [CFG_W-1:0] RST_MAX_DIM    = 13'd320;

  // Default upper bound on any image side.
  localparam int DEFAULT_MAX_SIDE = 4096;

endpackage

### hw/rtl/nearest_neighbor_downscaler.sv
// Nearest-neighbour downscaler for RGB pixels in raster order.
// A kept pixel is registered and appears on the output in the cycle after it is accepted.
// Throughput: one source pixel per cycle while the output is not stalled; the keep test is a few adds and compares.
// Reset (rst_n, synchronous, active low) loads 640 x 480 with a 320 limit and
// clears all frame counters; the input is held off after reset and after each
// configuration write while the scale products settle.
module nearest_neighbor_downscaler #(
  parameter int MaxSide = nnd_pkg::DEFAULT_MAX_SIDE
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [nnd_pkg::IDX_W-1:0]   cfg_addr,
  input  logic [nnd_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // red_in [7:0], green_in [15:8], blue_in [23:16]
  input  logic [nnd_pkg::IN_W-1:0]    in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // red_out [7:0], green_out [15:8], blue_out [23:16], out_col [35:24], out_row [47:36]
  output logic [nnd_pkg::OUT_W-1:0]   out_tdata,
  // frame_end
  output logic                        out_tlast
);
  import nnd_pkg::*;

  localparam int DW = $clog2(MaxSide + 1);
  localparam int SW = 2 * DW + 1;

  logic          settle_r;
  logic [DW-1:0] w_last;
  logic [DW-1:0] h_last;
  logic [DW-1:0] m;
  logic [DW-1:0] l;
  logic [SW-1:0] l2;
  logic [SW-1:0] wm;
  logic [SW-1:0] hm;

  // Configuration registers and derived scale values.
  nnd_geom #(
    .MaxSide (MaxSide),
    .DW      (DW),
    .SW      (SW)
  ) u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .settle_r  (settle_r),
    .w_last_r  (w_last),
    .h_last_r  (h_last),
    .m_r       (m),
    .l_r       (l),
    .l2_r      (l2),
    .wm_r      (wm),
    .hm_r      (hm)
  );

  // Pixel selection and result register; any write restarts the frame.
  nnd_sampler #(
    .MaxSide (MaxSide),
    .DW      (DW),
    .SW      (SW)
  ) u_sampler (
    .clk        (clk),
    .rst_n      (rst_n),
    .restart    (cfg_we),
    .settle     (settle_r),
    .w_last     (w_last),
    .h_last     (h_last),
    .m          (m),
    .l          (l),
    .l2         (l2),
    .wm         (wm),
    .hm         (hm),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

### hw/rtl/nnd_geom.sv
module nnd_geom #(
  parameter int MaxSide = nnd_pkg::DEFAULT_MAX_SIDE,
  parameter int DW      = $clog2(MaxSide + 1),
  parameter int SW      = 2 * DW + 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [nnd_pkg::IDX_W-1:0]  cfg_addr,
  input  logic [nnd_pkg::CFG_W-1:0]  cfg_wdata,
  output logic                       settle_r,
  output logic [DW-1:0]              w_last_r,
  output logic [DW-1:0]              h_last_r,
  output logic [DW-1:0]              m_r,
  output logic [DW-1:0]              l_r,
  output logic [SW-1:0]              l2_r,
  output logic [SW-1:0]              wm_r,
  output logic [SW-1:0]              hm_r
);
  import nnd_pkg::*;

  localparam int CW = (DW > CFG_W) ? DW : CFG_W;

  logic [CFG_W-1:0] src_width_r;
  logic [CFG_W-1:0] src_height_r;
  logic [CFG_W-1:0] max_dim_r;
  logic [DW-1:0]    w_c;
  logic [DW-1:0]    h_c;
  logic [DW-1:0]    m_c;
  logic [DW-1:0]    l_wh;
  logic [DW-1:0]    l_c;

  // Out-of-range sides: zero is taken as one, anything above the bound as the bound.
  function automatic logic [DW-1:0] clamp_side(input logic [CFG_W-1:0] raw);
    logic [DW-1:0] res;
    if (raw == '0) begin
      res = DW'(1);
    end else if (CW'(raw) > CW'(MaxSide)) begin
      res = DW'(MaxSide);
    end else begin
      res = DW'(raw);
    end
    return res;
  endfunction

  // Configuration registers; an index beyond the list changes nothing.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= RST_SRC_WIDTH;
      src_height_r <= RST_SRC_HEIGHT;
      max_dim_r    <= RST_MAX_DIM;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_SRC_WIDTH:  src_width_r  <= cfg_wdata;
        REG_SRC_HEIGHT: src_height_r <= cfg_wdata;
        REG_MAX_DIM:    max_dim_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Clamped sides and the scale reference, the largest of the three.
  always_comb begin
    w_c  = clamp_side(src_width_r);
    h_c  = clamp_side(src_height_r);
    m_c  = clamp_side(max_dim_r);
    l_wh = (w_c > h_c) ? w_c : h_c;
    l_c  = (m_c > l_wh) ? m_c : l_wh;
  end

  // Derived geometry, registered behind the configuration registers.
  always_ff @(posedge clk) begin
    w_last_r <= w_c - DW'(1);
    h_last_r <= h_c - DW'(1);
    m_r      <= m_c;
    l_r      <= l_c;
    l2_r     <= SW'(l_c) << 1;
    wm_r     <= SW'(w_c) * SW'(m_c);
    hm_r     <= SW'(h_c) * SW'(m_c);
  end

  // Inputs are held off for the cycle in which the geometry settles.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= 1'b1;
    end else begin
      settle_r <= cfg_we;
    end
  end

endmodule

### hw/rtl/nnd_sampler.sv
module nnd_sampler #(
  parameter int MaxSide = nnd_pkg::DEFAULT_MAX_SIDE,
  parameter int DW      = $clog2(MaxSide + 1),
  parameter int SW      = 2 * DW + 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        restart,
  input  logic                        settle,
  input  logic [DW-1:0]               w_last,
  input  logic [DW-1:0]               h_last,
  input  logic [DW-1:0]               m,
  input  logic [DW-1:0]               l,
  input  logic [SW-1:0]               l2,
  input  logic [SW-1:0]               wm,
  input  logic [SW-1:0]               hm,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [nnd_pkg::IN_W-1:0]    in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [nnd_pkg::OUT_W-1:0]   out_tdata,
  output logic                        out_tlast
);
  import nnd_pkg::*;

  localparam int PW = (DW > POS_W) ? DW : POS_W;

  logic [DW-1:0]      source_col_r;
  logic [DW-1:0]      source_row_r;
  logic [DW-1:0]      kept_col_r;
  logic [DW-1:0]      kept_row_r;
  logic [SW-1:0]      col_target_sum_r;
  logic [SW-1:0]      col_source_sum_r;
  logic [SW-1:0]      row_target_sum_r;
  logic [SW-1:0]      row_source_sum_r;
  logic               row_kept_flag_r;
  logic               out_valid_r;
  logic [IN_W-1:0]    pix_r;
  logic [POS_W-1:0]   col_r;
  logic [POS_W-1:0]   row_r;
  logic               last_r;

  logic               accept;
  logic               row_in_range;
  logic               row_keep;
  logic               col_in_range;
  logic               keep;
  logic               last_col;
  logic               last_row;
  logic               row_end;
  logic               frame_done;
  logic [PW-1:0]      col_wide;
  logic [PW-1:0]      row_wide;

  // A new word is taken whenever the geometry is not settling and the result register is free or being emptied.
  assign in_tready = !settle && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;

  // Keep decision. Index k is below the output size n = floor(S*m/l), at least 1,
  // exactly when k is zero or (k+1)*l <= S*m; the last index fails that for k+1.
  always_comb begin
    row_in_range = (kept_row_r == '0) || (row_target_sum_r + SW'(l) <= hm);
    row_keep     = (source_col_r == '0)
                   ? (row_in_range && (row_target_sum_r < row_source_sum_r + SW'(m)))
                   : row_kept_flag_r;
    col_in_range = (kept_col_r == '0) || (col_target_sum_r + SW'(l) <= wm);
    keep         = row_keep && col_in_range
                   && (col_target_sum_r < col_source_sum_r + SW'(m));
    last_col     = (col_target_sum_r + l2) > wm;
    last_row     = (row_target_sum_r + l2) > hm;
    row_end      = (source_col_r == w_last);
    frame_done   = row_end && (source_row_r == h_last);
    col_wide     = PW'(kept_col_r);
    row_wide     = PW'(kept_row_r);
  end

  // Frame position counters and running sums.
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      source_col_r     <= '0;
      source_row_r     <= '0;
      kept_col_r       <= '0;
      kept_row_r       <= '0;
      col_target_sum_r <= '0;
      col_source_sum_r <= '0;
      row_target_sum_r <= '0;
      row_source_sum_r <= '0;
      row_kept_flag_r  <= 1'b0;
    end else if (accept) begin
      if (frame_done) begin
        source_col_r     <= '0;
        source_row_r     <= '0;
        kept_col_r       <= '0;
        kept_row_r       <= '0;
        col_target_sum_r <= '0;
        col_source_sum_r <= '0;
        row_target_sum_r <= '0;
        row_source_sum_r <= '0;
        row_kept_flag_r  <= 1'b0;
      end else if (row_end) begin
        source_col_r     <= '0;
        source_row_r     <= source_row_r + DW'(1);
        kept_col_r       <= '0;
        col_target_sum_r <= '0;
        col_source_sum_r <= '0;
        row_source_sum_r <= row_source_sum_r + SW'(m);
        row_kept_flag_r  <= row_keep;
        if (row_keep) begin
          kept_row_r       <= kept_row_r + DW'(1);
          row_target_sum_r <= row_target_sum_r + SW'(l);
        end
      end else begin
        source_col_r     <= source_col_r + DW'(1);
        col_source_sum_r <= col_source_sum_r + SW'(m);
        row_kept_flag_r  <= row_keep;
        if (keep) begin
          kept_col_r       <= kept_col_r + DW'(1);
          col_target_sum_r <= col_target_sum_r + SW'(l);
        end
      end
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= keep;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (accept && keep) begin
      pix_r  <= in_tdata;
      col_r  <= col_wide[POS_W-1:0];
      row_r  <= row_wide[POS_W-1:0];
      last_r <= last_col && last_row;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {row_r, col_r, pix_r};
  assign out_tlast  = last_r;

endmodule

### bench/downscale_checker.sv
`timescale 1ns / 1ps

// Watches the pixel channels of the downscaler, works out which source pixels are
// kept and compares every output word with the oldest kept pixel still waiting.
module downscale_checker #(
  parameter int MaxSide = nnd_pkg::DEFAULT_MAX_SIDE
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [nnd_pkg::IDX_W-1:0]   cfg_addr,
  input  logic [nnd_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic                        in_tvalid,
  input  logic                        in_tready,
  // red_in [7:0], green_in [15:8], blue_in [23:16]
  input  logic [nnd_pkg::IN_W-1:0]    in_tdata,
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  // red_out [7:0], green_out [15:8], blue_out [23:16], out_col [35:24], out_row [47:36]
  input  logic [nnd_pkg::OUT_W-1:0]   out_tdata,
  // frame_end
  input  logic                        out_tlast,
  output int                          fail_count,
  output int                          n_pending
);
  import nnd_pkg::*;

  typedef struct {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [POS_W-1:0]   col;
    logic [POS_W-1:0]   row;
    logic               frame_end;
  } kept_pixel_t;

  // Register copies, as written.
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  logic [CFG_W-1:0] limit_reg;

  // Frame position and the running sums of the sampling grid.
  logic [CFG_W-1:0] src_col;
  logic [CFG_W-1:0] src_row;
  logic [CFG_W-1:0] dst_col;
  logic [CFG_W-1:0] dst_row;
  logic [24:0]      col_goal;
  logic [24:0]      col_pos;
  logic [24:0]      row_goal;
  logic [24:0]      row_pos;
  logic             row_on;

  kept_pixel_t kept_pixels_q[$];

  function automatic logic [CFG_W-1:0] clamp_side(input logic [CFG_W-1:0] v);
    if (v == '0) return CFG_W'(1);
    if (v > MaxSide) return CFG_W'(MaxSide);
    return v;
  endfunction

  // Output side: floor(side * limit / l), l the largest of width, height and limit, never below one.
  function automatic logic [CFG_W-1:0] scaled_side(input logic [CFG_W-1:0] side,
                                                   input logic [CFG_W-1:0] m,
                                                   input logic [CFG_W-1:0] l);
    logic [25:0] prod;
    logic [25:0] quot;
    prod = side * m;
    quot = prod / l;
    return (quot == '0) ? CFG_W'(1) : quot[CFG_W-1:0];
  endfunction

  function automatic void restart_frame();
    src_col  = '0;
    src_row  = '0;
    dst_col  = '0;
    dst_row  = '0;
    col_goal = '0;
    col_pos  = '0;
    row_goal = '0;
    row_pos  = '0;
    row_on   = 1'b0;
  endfunction

  // Advances the frame by one source pixel; returns 1 when the pixel is kept.
  function automatic bit sample_pixel(input logic [IN_W-1:0] rgb, output kept_pixel_t px);
    logic [CFG_W-1:0] w;
    logic [CFG_W-1:0] h;
    logic [CFG_W-1:0] m;
    logic [CFG_W-1:0] l;
    logic [CFG_W-1:0] wo;
    logic [CFG_W-1:0] ho;
    bit               kept;
    w = clamp_side(width_reg);
    h = clamp_side(height_reg);
    m = clamp_side(limit_reg);
    l = (w > h) ? w : h;
    if (m > l) l = m;
    wo = scaled_side(w, m, l);
    ho = scaled_side(h, m, l);
    kept = 1'b0;
    px = '{default: '0};

    // The row decision is taken on its first pixel.
    if (src_col == '0) row_on = (dst_row < ho) && (row_goal < row_pos + m);

    if (row_on && dst_col < wo && col_goal < col_pos + m) begin
      px.red       = rgb[7:0];
      px.green     = rgb[15:8];
      px.blue      = rgb[23:16];
      px.col       = dst_col[POS_W-1:0];
      px.row       = dst_row[POS_W-1:0];
      px.frame_end = (dst_col == wo - 1'b1) && (dst_row == ho - 1'b1);
      dst_col      = dst_col + 1'b1;
      col_goal     = col_goal + l;
      kept         = 1'b1;
    end

    col_pos = col_pos + m;
    src_col = src_col + 1'b1;

    // End of a source row, and of the frame after the last row.
    if (src_col >= w) begin
      src_col  = '0;
      dst_col  = '0;
      col_goal = '0;
      col_pos  = '0;
      if (row_on) begin
        dst_row  = dst_row + 1'b1;
        row_goal = row_goal + l;
      end
      row_pos = row_pos + m;
      src_row = src_row + 1'b1;
      if (src_row >= h) restart_frame();
    end
    return kept;
  endfunction

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      fail_count++;
    end
  endtask

  // Results are checked before this edge's input is predicted, so that a spurious
  // word can never be matched against a pixel accepted on the same edge.
  always @(posedge clk) begin : watch
    kept_pixel_t want;
    kept_pixel_t got;
    if (!rst_n) begin
      width_reg  = RST_SRC_WIDTH;
      height_reg = RST_SRC_HEIGHT;
      limit_reg  = RST_MAX_DIM;
      restart_frame();
      kept_pixels_q.delete();
      fail_count = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.red       = out_tdata[7:0];
        got.green     = out_tdata[15:8];
        got.blue      = out_tdata[23:16];
        got.col       = out_tdata[35:24];
        got.row       = out_tdata[47:36];
        got.frame_end = out_tlast;
        if (kept_pixels_q.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual data %h last %b",
                   $time, out_tdata, out_tlast);
          fail_count++;
        end else begin
          want = kept_pixels_q.pop_front();
          check_field("red", want.red, got.red);
          check_field("green", want.green, got.green);
          check_field("blue", want.blue, got.blue);
          check_field("out_col", want.col, got.col);
          check_field("out_row", want.row, got.row);
          check_field("frame_end", want.frame_end, got.frame_end);
        end
      end

      // Any write, even to an unused index, starts a new frame.
      if (cfg_we) begin
        case (cfg_addr)
          REG_SRC_WIDTH: begin
            width_reg = cfg_wdata;
          end
          REG_SRC_HEIGHT: begin
            height_reg = cfg_wdata;
          end
          REG_MAX_DIM: begin
            limit_reg = cfg_wdata;
          end
          default: begin
          end
        endcase
        restart_frame();
      end

      if (in_tvalid && in_tready) begin
        if (sample_pixel(in_tdata, want)) kept_pixels_q = {kept_pixels_q, want};
      end
    end
    n_pending <= kept_pixels_q.size();
  end

endmodule

### bench/tb_nearest_neighbor_downscaler.sv
`timescale 1ns / 1ps

module tb_nearest_neighbor_downscaler;
  import nnd_pkg::*;

  localparam int CLK_PERIOD    = 8;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RANDOM_PIXELS = 1250;
  localparam int HOLD_CYCLES   = 150;
  localparam int SIDE_TOP      = DEFAULT_MAX_SIDE;

  // Index beyond the register list: restarts the frame and changes nothing else.
  localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam logic [2:0] WRITE_ALL  = 3'b111;
  localparam logic [2:0] WRITE_NONE = 3'b000;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               cfg_we     = 1'b0;
  logic [IDX_W-1:0]   cfg_addr   = '0;
  logic [CFG_W-1:0]   cfg_wdata  = '0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [IN_W-1:0]    in_tdata   = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [OUT_W-1:0]   out_tdata;
  logic               out_tlast;

  int fail_count;
  int n_pending;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_requests  = 0;
  int hold_served    = 0;
  int hold_left      = 0;
  int cycle_count    = 0;
  int pixels_sent    = 0;

  // Settings in force, for sizing the frames sent.
  logic [CFG_W-1:0] cur_width  = RST_SRC_WIDTH;
  logic [CFG_W-1:0] cur_height = RST_SRC_HEIGHT;

  nearest_neighbor_downscaler i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  downscale_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .n_pending  (n_pending)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_requests != hold_served) begin
      out_tready  <= 1'b0;
      hold_left   <= HOLD_CYCLES - 1;
      hold_served <= hold_served + 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Offers one pixel word, after random idle cycles, and waits for it to be taken.
  task automatic send_pixel(input logic [IN_W-1:0] rgb);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= rgb;
    do @(posedge clk); while (!in_tready);
    pixels_sent++;
  endtask

  task automatic send_random(input int count);
    repeat (count) send_pixel(IN_W'($urandom));
  endtask

  // Waits until every kept pixel has come out and the block has gone quiet.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  // Loads a new setting once the block is idle; a clear mask bit skips a register.
  task automatic load_setting(input logic [2:0] mask, input logic [CFG_W-1:0] w,
                              input logic [CFG_W-1:0] h, input logic [CFG_W-1:0] m,
                              input bit poke_unused);
    drain();
    if (mask[0]) begin
      write_reg(REG_SRC_WIDTH, w);
      cur_width = w;
    end
    if (mask[1]) begin
      write_reg(REG_SRC_HEIGHT, h);
      cur_height = h;
    end
    if (mask[2]) write_reg(REG_MAX_DIM, m);
    if (poke_unused) write_reg(REG_UNUSED, CFG_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  // Mostly small sides, with zero, oversized and full-range values now and then.
  function automatic logic [CFG_W-1:0] random_side(input int small_top);
    int roll;
    roll = $urandom_range(99);
    if (roll < 75) return CFG_W'($urandom_range(1, small_top));
    if (roll < 83) return '0;
    if (roll < 91) return CFG_W'($urandom_range(SIDE_TOP + 1, 8191));
    return CFG_W'($urandom_range(1, SIDE_TOP));
  endfunction

  function automatic int used_side(input logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (v > SIDE_TOP) return SIDE_TOP;
    return int'(v);
  endfunction

  initial begin : stimulus
    logic [CFG_W-1:0] w;
    logic [CFG_W-1:0] h;
    logic [CFG_W-1:0] m;
    logic [2:0]       mask;
    int               frame_size;
    int               count;
    int               phase;
    int               random_start;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset setting, 640 x 480 limited to 320: every other pixel of row 0 is kept.
    send_pixel(24'h000000);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h5A5A5A);
    send_pixel(24'hA5A5A5);

    // Three by two with a limit of three: nothing is scaled, frame end on the last.
    load_setting(WRITE_ALL, 13'd3, 13'd2, 13'd3, 1'b0);
    send_pixel(24'h0000FF);
    send_pixel(24'h00FF00);
    send_pixel(24'hFF0000);
    send_pixel(24'h123456);
    send_pixel(24'hEDCBA9);
    send_pixel(24'hFFFFFF);

    // Zero in every register is read as one, so each pixel is a whole frame.
    load_setting(WRITE_ALL, '0, '0, '0, 1'b0);
    send_pixel(24'h80807F);
    send_pixel(24'h7F7F80);

    // Sides above the maximum clamp to it; a limit of one keeps a single pixel.
    load_setting(WRITE_ALL, '1, '1, 13'd1, 1'b0);
    send_random(3);

    // A write to the unused index leaves the registers alone but restarts the frame.
    load_setting(WRITE_NONE, '0, '0, '0, 1'b1);
    send_random(3);

    // Widest row at the largest limit: every pixel kept, only the start of the row.
    load_setting(WRITE_ALL, 13'd4096, 13'd1, '1, 1'b0);
    send_random(200);

    // Tallest column, only its start.
    load_setting(WRITE_ALL, 13'd1, 13'd4096, 13'd4096, 1'b0);
    send_random(40);

    // Back pressure: the receiver holds off while pixels keep coming without gaps.
    load_setting(WRITE_ALL, 13'd8, 13'd8, 13'd8, 1'b0);
    hold_requests <= hold_requests + 1;
    send_random(64);

    // Random settings, mostly whole frames, cycling through the idling patterns.
    phase        = 0;
    random_start = pixels_sent;
    while (pixels_sent - random_start < RANDOM_PIXELS) begin
      case (phase % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 61;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 61;
        end
        default: begin
          send_idle_pct  = 19;
          recv_stall_pct = 19;
        end
      endcase
      w    = random_side(12);
      h    = random_side(10);
      m    = random_side(16);
      mask = ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : WRITE_ALL;
      load_setting(mask, w, h, m, $urandom_range(9) == 0);

      frame_size = used_side(cur_width) * used_side(cur_height);
      if (frame_size <= 256) begin
        count = frame_size * $urandom_range(1, 3);
        // Now and then a short frame, cut off by the next setting.
        if ($urandom_range(3) == 0) count += $urandom_range(frame_size - 1);
      end else begin
        count = $urandom_range(1, 120);
      end
      // The last batch stops at the planned number of words.
      if (count > RANDOM_PIXELS - (pixels_sent - random_start)) begin
        count = RANDOM_PIXELS - (pixels_sent - random_start);
      end
      send_random(count);
      phase++;
    end

    drain();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
